// ===== design/allm_pkg.sv =====
// Package for the array linked list manager: opcodes, status codes, phase and
// microcode types, and the microcode table that sequences every operation.
// No dependencies.
`timescale 1ns / 1ps

package allm_pkg;

   typedef enum logic [1:0] {
      OP_INSERT_AFTER,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_DELETE
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_INDEX,
      ST_INACTIVE,
      ST_FULL
   } status_type;

   typedef enum logic [1:0] {
      PH_CLEAR,
      PH_IDLE,
      PH_RUN
   } phase_type;

   // jump conditions
   typedef enum logic [1:0] {
      CND_NONE,
      CND_BAD_INS,
      CND_BAD_DEL,
      CND_NODE
   } cond_type;

   typedef enum logic [1:0] {
      A_POS,
      A_FRESH,
      A_AFTER,
      A_BEFORE
   } addr_sel_type;

   typedef enum logic [2:0] {
      D_POS,
      D_FRESH,
      D_AFTER,
      D_BEFORE,
      D_ZERO
   } data_sel_type;

   typedef enum logic [1:0] {
      CM_NONE,
      CM_INSERT,
      CM_DELETE,
      CM_ERROR
   } commit_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type UC_INSERT = 4'd0;
   localparam step_type UC_DELETE = 4'd4;
   localparam step_type UC_ERROR  = 4'd8;

   typedef struct packed {
      logic         rd_fresh;
      logic         ld_after;
      logic         ld_before;
      logic         ld_link;
      logic         ld_removed;
      cond_type     cond;
      step_type     target;
      logic         next_we;
      addr_sel_type next_wa;
      data_sel_type next_wd;
      logic         prev_we;
      addr_sel_type prev_wa;
      data_sel_type prev_wd;
      logic         value_we;
      logic         free_we;
      addr_sel_type free_wa;
      logic         free_wd;
      logic         ord_del;
      commit_type   commit;
      logic         done;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(step_type step);
      ucode_word_type w;
      w = '0;
      case (step)
         // insert: read next/free at pos, check index
         4'd0: begin
            w.cond   = CND_BAD_INS;
            w.target = UC_ERROR;
         end
         // latch successor of pos, read link of fresh node, check node / full
         4'd1: begin
            w.rd_fresh = 1'b1;
            w.ld_after = 1'b1;
            w.cond     = CND_NODE;
            w.target   = UC_ERROR;
         end
         // fill the fresh node
         4'd2: begin
            w.ld_link  = 1'b1;
            w.next_we  = 1'b1;
            w.next_wa  = A_FRESH;
            w.next_wd  = D_AFTER;
            w.prev_we  = 1'b1;
            w.prev_wa  = A_FRESH;
            w.prev_wd  = D_POS;
            w.value_we = 1'b1;
            w.free_we  = 1'b1;
            w.free_wa  = A_FRESH;
            w.free_wd  = 1'b0;
         end
         // splice it in
         4'd3: begin
            w.next_we = 1'b1;
            w.next_wa = A_POS;
            w.next_wd = D_FRESH;
            w.prev_we = 1'b1;
            w.prev_wa = A_AFTER;
            w.prev_wd = D_FRESH;
            w.commit  = CM_INSERT;
            w.done    = 1'b1;
         end
         // delete: read all stores at pos, check index, order flag
         4'd4: begin
            w.cond    = CND_BAD_DEL;
            w.target  = UC_ERROR;
            w.ord_del = 1'b1;
         end
         4'd5: begin
            w.ld_after   = 1'b1;
            w.ld_before  = 1'b1;
            w.ld_removed = 1'b1;
            w.cond       = CND_NODE;
            w.target     = UC_ERROR;
         end
         // unlink from neighbours
         4'd6: begin
            w.next_we = 1'b1;
            w.next_wa = A_BEFORE;
            w.next_wd = D_AFTER;
            w.prev_we = 1'b1;
            w.prev_wa = A_AFTER;
            w.prev_wd = D_BEFORE;
            w.free_we = 1'b1;
            w.free_wa = A_POS;
            w.free_wd = 1'b1;
         end
         // push onto free chain
         4'd7: begin
            w.next_we = 1'b1;
            w.next_wa = A_POS;
            w.next_wd = D_FRESH;
            w.prev_we = 1'b1;
            w.prev_wa = A_POS;
            w.prev_wd = D_ZERO;
            w.commit  = CM_DELETE;
            w.done    = 1'b1;
         end
         4'd8: begin
            w.commit = CM_ERROR;
            w.done   = 1'b1;
         end
         default: begin
            w.commit = CM_ERROR;
            w.done   = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/allm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module allm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/array_linked_list_manager.sv =====
// Top level of the array linked list manager: microcoded sequencer over four
// node stores. Depends on allm_pkg and allm_ram.
`timescale 1ns / 1ps

// Doubly linked list in a fixed store of NODE_COUNT nodes plus sentinel node 0,
// with free nodes on a singly linked chain.
// Command channel: a word (req_opcode, req_position, req_value) is taken at a
// clock edge where start is high and busy is low.
// Result channel: rsp_strobe is high for one cycle with rsp_new_index,
// rsp_removed_value, rsp_status and rsp_in_order; the receiver cannot stall,
// so nothing here waits on it.
// Timing: a good insert or delete runs four microcode steps and its result
// shows in the cycle after the last step. busy drops in the last step, so a
// new word may be taken then. A bad index ends after two steps, an inactive
// node or a full store after three. The step count is set by the single-ported
// stores: each operation reads and rewrites up to three nodes, two links per
// store.
// Reset: a clearing pass over every node, sentinel included, rebuilds the free
// chain and clears the stores; busy is high throughout.

module array_linked_list_manager import allm_pkg::*; #(
   parameter int NODE_COUNT  = 255,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_new_index,
   output logic signed [31:0] rsp_removed_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_in_order
);

   localparam int DEPTH = NODE_COUNT + 1;
   localparam int IW    = $clog2(DEPTH);

   phase_type      phase_ff, phase_in;
   step_type       step_ff, step_in;
   ucode_word_type cw;
   logic           accept, sweep, cond_hit;
   status_type     err_status;

   opcode_type             op_ff, op_in;
   logic [7:0]             position_ff, position_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] removed_ff, removed_in;
   logic [IW-1:0]          free_head_ff, free_head_in;
   logic [IW-1:0]          used_ff, used_in;
   logic [IW-1:0]          tail_ff, tail_in;
   logic [IW-1:0]          after_ff, after_in;
   logic [IW-1:0]          before_ff, before_in;
   logic [IW-1:0]          link_ff, link_in;
   logic [IW-1:0]          clr_ff, clr_in;
   logic                   order_ff, order_in;
   status_type             status_ff, status_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]         rsp_new_index_ff, rsp_new_index_in;
   logic signed [31:0] rsp_removed_ff, rsp_removed_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_in_order_ff, rsp_in_order_in;

   logic [IW-1:0] eff_pos;
   logic          full, bad_ins, bad_del;

   logic                   next_we, prev_we, free_we, value_we;
   logic [IW-1:0]          next_wa, prev_wa, free_wa, next_rd_addr;
   logic [IW-1:0]          next_wd, prev_wd, next_q, prev_q;
   logic                   free_wd, free_q;
   logic [VALUE_WIDTH-1:0] value_wd, value_q;

   step_type entry;

   function automatic logic [IW-1:0] addr_mux(addr_sel_type s, logic [IW-1:0] pos,
                                              logic [IW-1:0] fresh, logic [IW-1:0] aft,
                                              logic [IW-1:0] bef);
      logic [IW-1:0] r;
      case (s)
         A_POS:    r = pos;
         A_FRESH:  r = fresh;
         A_AFTER:  r = aft;
         A_BEFORE: r = bef;
         default:  r = pos;
      endcase
      return r;
   endfunction

   function automatic logic [IW-1:0] data_mux(data_sel_type s, logic [IW-1:0] pos,
                                              logic [IW-1:0] fresh, logic [IW-1:0] aft,
                                              logic [IW-1:0] bef);
      logic [IW-1:0] r;
      case (s)
         D_POS:    r = pos;
         D_FRESH:  r = fresh;
         D_AFTER:  r = aft;
         D_BEFORE: r = bef;
         D_ZERO:   r = '0;
         default:  r = '0;
      endcase
      return r;
   endfunction

   // position used by the current operation; push back goes after the tail
   always_comb begin
      case (op_ff)
         OP_PUSH_FRONT: eff_pos = '0;
         OP_PUSH_BACK:  eff_pos = tail_ff;
         default:       eff_pos = IW'(position_ff);
      endcase
   end

   assign full    = (used_ff == IW'(NODE_COUNT));
   assign bad_ins = (op_ff == OP_INSERT_AFTER) && (int'(position_ff) > NODE_COUNT);
   assign bad_del = (position_ff == 8'd0) || (int'(position_ff) > NODE_COUNT);
   assign entry   = (opcode_type'(req_opcode) == OP_DELETE) ? UC_DELETE : UC_INSERT;

   always_comb begin
      case (cw.cond)
         CND_BAD_INS: cond_hit = bad_ins;
         CND_BAD_DEL: cond_hit = bad_del;
         CND_NODE:    cond_hit = free_q | ((op_ff != OP_DELETE) & full);
         default:     cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.cond)
         CND_BAD_INS: err_status = ST_BAD_INDEX;
         CND_BAD_DEL: err_status = ST_BAD_INDEX;
         CND_NODE:    err_status = free_q ? ST_INACTIVE : ST_FULL;
         default:     err_status = ST_OK;
      endcase
   end

   // sequencer next state
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      case (phase_ff)
         PH_CLEAR: begin
            if (clr_ff == IW'(NODE_COUNT)) begin
               phase_in = PH_IDLE;
            end
         end
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_RUN;
               step_in  = entry;
            end
         end
         PH_RUN: begin
            if (cw.done) begin
               if (start) begin
                  step_in = entry;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else if (cond_hit) begin
               step_in = cw.target;
            end else begin
               step_in = step_ff + step_type'(1);
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      cw    = '0;
      busy  = 1'b1;
      sweep = 1'b0;
      case (phase_ff)
         PH_CLEAR: sweep = 1'b1;
         PH_IDLE:  busy  = 1'b0;
         PH_RUN: begin
            cw   = ucode_rom(step_ff);
            busy = ~cw.done;
         end
         default: busy = 1'b0;
      endcase
   end

   assign accept = start & ~busy;

   // store ports: clearing pass or microcode
   always_comb begin
      if (sweep) begin
         next_we  = 1'b1;
         next_wa  = clr_ff;
         next_wd  = (clr_ff == '0 || clr_ff == IW'(NODE_COUNT)) ? '0 : clr_ff + IW'(1);
         prev_we  = 1'b1;
         prev_wa  = clr_ff;
         prev_wd  = '0;
         free_we  = 1'b1;
         free_wa  = clr_ff;
         free_wd  = (clr_ff != '0);
         value_we = 1'b1;
         value_wd = '0;
      end else begin
         next_we  = cw.next_we;
         next_wa  = addr_mux(cw.next_wa, eff_pos, free_head_ff, after_ff, before_ff);
         next_wd  = data_mux(cw.next_wd, eff_pos, free_head_ff, after_ff, before_ff);
         prev_we  = cw.prev_we;
         prev_wa  = addr_mux(cw.prev_wa, eff_pos, free_head_ff, after_ff, before_ff);
         prev_wd  = data_mux(cw.prev_wd, eff_pos, free_head_ff, after_ff, before_ff);
         free_we  = cw.free_we;
         free_wa  = addr_mux(cw.free_wa, eff_pos, free_head_ff, after_ff, before_ff);
         free_wd  = cw.free_wd;
         value_we = cw.value_we;
         value_wd = value_ff;
      end
   end

   assign next_rd_addr = cw.rd_fresh ? free_head_ff : eff_pos;

   // datapath next values
   always_comb begin
      op_in            = op_ff;
      position_in      = position_ff;
      value_in         = value_ff;
      removed_in       = removed_ff;
      free_head_in     = free_head_ff;
      used_in          = used_ff;
      tail_in          = tail_ff;
      after_in         = after_ff;
      before_in        = before_ff;
      link_in          = link_ff;
      clr_in           = clr_ff;
      order_in         = order_ff;
      status_in        = status_ff;
      rsp_strobe_in    = 1'b0;
      rsp_new_index_in = rsp_new_index_ff;
      rsp_removed_in   = rsp_removed_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_in_order_in  = rsp_in_order_ff;

      if (accept) begin
         op_in       = opcode_type'(req_opcode);
         position_in = req_position;
         value_in    = VALUE_WIDTH'(req_value);
      end
      if (sweep) begin
         clr_in = clr_ff + IW'(1);
      end
      if (cw.ld_after) begin
         after_in = next_q;
      end
      if (cw.ld_before) begin
         before_in = prev_q;
      end
      if (cw.ld_link) begin
         link_in = next_q;
      end
      if (cw.ld_removed) begin
         removed_in = value_q;
      end
      if (cond_hit) begin
         status_in = err_status;
      end
      // order holds only while every change is at the tail
      if ((cw.ord_del && !cond_hit) || cw.commit == CM_INSERT) begin
         order_in = order_ff & (tail_ff == eff_pos);
      end
      // tail mirrors the sentinel's prev link
      if (prev_we && prev_wa == '0) begin
         tail_in = prev_wd;
      end

      case (cw.commit)
         CM_INSERT: begin
            free_head_in     = link_ff;
            used_in          = used_ff + IW'(1);
            rsp_strobe_in    = 1'b1;
            rsp_new_index_in = 8'(free_head_ff);
            rsp_removed_in   = '0;
            rsp_status_in    = ST_OK;
            rsp_in_order_in  = order_in;
         end
         CM_DELETE: begin
            free_head_in     = eff_pos;
            used_in          = used_ff - IW'(1);
            rsp_strobe_in    = 1'b1;
            rsp_new_index_in = '0;
            rsp_removed_in   = 32'($signed(removed_ff));
            rsp_status_in    = ST_OK;
            rsp_in_order_in  = order_in;
         end
         CM_ERROR: begin
            rsp_strobe_in    = 1'b1;
            rsp_new_index_in = '0;
            rsp_removed_in   = '0;
            rsp_status_in    = status_ff;
            rsp_in_order_in  = order_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_CLEAR;
         step_ff         <= '0;
         clr_ff          <= '0;
         free_head_ff    <= IW'(1);
         used_ff         <= '0;
         tail_ff         <= '0;
         order_ff        <= 1'b1;
         status_ff       <= ST_OK;
         rsp_strobe_ff   <= 1'b0;
         rsp_in_order_ff <= 1'b1;
      end else begin
         phase_ff        <= phase_in;
         step_ff         <= step_in;
         clr_ff          <= clr_in;
         free_head_ff    <= free_head_in;
         used_ff         <= used_in;
         tail_ff         <= tail_in;
         order_ff        <= order_in;
         status_ff       <= status_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         rsp_in_order_ff <= rsp_in_order_in;
      end
      op_ff            <= op_in;
      position_ff      <= position_in;
      value_ff         <= value_in;
      removed_ff       <= removed_in;
      after_ff         <= after_in;
      before_ff        <= before_in;
      link_ff          <= link_in;
      rsp_new_index_ff <= rsp_new_index_in;
      rsp_removed_ff   <= rsp_removed_in;
      rsp_status_ff    <= rsp_status_in;
   end

   allm_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (next_rd_addr),
      .rd_data (next_q)
   );

   allm_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (eff_pos),
      .rd_data (prev_q)
   );

   allm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_wa),
      .wr_data (free_wd),
      .rd_addr (eff_pos),
      .rd_data (free_q)
   );

   allm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (sweep ? clr_ff : free_head_ff),
      .wr_data (value_wd),
      .rd_addr (eff_pos),
      .rd_data (value_q)
   );

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_new_index     = rsp_new_index_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_in_order      = rsp_in_order_ff;

endmodule

// ===== design/allm_checker.sv =====
// Port-level checks for the array linked list manager, bound to the top level.
// Depends on allm_pkg and array_linked_list_manager.
`timescale 1ns / 1ps

module allm_checker import allm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [7:0]         rsp_new_index,
   input logic signed [31:0] rsp_removed_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_in_order
);

   // a taken word always keeps the sequencer busy for at least one step
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low right after a word was taken");

   // results are never back to back
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_new_index == 8'd0 && rsp_removed_value == 32'sd0)
      else $error("error result carries index or value");

   // order flag is sticky once cleared
   a_order_sticky: assert property (@(posedge clock) disable iff (reset)
      !$rose(rsp_in_order))
      else $error("order flag set again");

endmodule

bind array_linked_list_manager allm_checker u_allm_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for array_linked_list_manager: a shadow copy of the node
// store predicts every result word, which is checked as it comes off the rsp_ port.
// Depends on allm_pkg and the design files.
`timescale 1ns / 1ps

module tb_top import allm_pkg::*; ();

   localparam int NODES       = 255;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0]         new_index;
      logic signed [31:0] removed_value;
      status_type         status;
      logic               in_order;
   } list_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_opcode = '0;
   logic [7:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [7:0]         rsp_new_index;
   logic signed [31:0] rsp_removed_value;
   logic [1:0]         rsp_status;
   logic               rsp_in_order;

   // shadow node store
   logic [7:0]         link_next [0:NODES];
   logic [7:0]         link_prev [0:NODES];
   logic               is_free [0:NODES];
   logic signed [31:0] payload [0:NODES];
   logic [7:0]         free_top;
   int                 in_use;
   logic               ordered;

   list_result_type expected_outcomes[$];
   int              fail_count = 0;
   int              idle_pct = 0;
   int              cycle_count = 0;

   array_linked_list_manager uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_new_index     (rsp_new_index),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_in_order      (rsp_in_order)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void clear_list_model();
      for (int i = 0; i <= NODES; i++) begin
         link_next[i] = 8'((i + 1) % (NODES + 1));
         link_prev[i] = '0;
         is_free[i]   = 1'b1;
         payload[i]   = '0;
      end
      link_next[0] = '0;
      is_free[0]   = 1'b0;
      free_top     = 8'd1;
      in_use       = 0;
      ordered      = 1'b1;
   endfunction

   // Applies one command to the shadow store and returns the word it should produce.
   // With 8-bit positions and 255 nodes an insert can never hit a bad index.
   function automatic list_result_type apply_list_op(input opcode_type op,
                                                     input logic [7:0] pos,
                                                     input logic signed [31:0] v);
      list_result_type r;
      logic [7:0]      anchor;
      logic [7:0]      fresh;
      logic [7:0]      after;
      logic [7:0]      prev_node;
      r = '0;
      if (op == OP_DELETE) begin
         if (pos == 8'd0) begin
            r.status = ST_BAD_INDEX;
         end else begin
            // flag drops even when the node turns out to be free
            if (link_prev[0] != pos) ordered = 1'b0;
            if (is_free[pos]) begin
               r.status = ST_INACTIVE;
            end else begin
               prev_node = link_prev[pos];
               after     = link_next[pos];
               link_next[prev_node] = after;
               link_prev[after]     = prev_node;
               r.removed_value = payload[pos];
               payload[pos]   = '0;
               is_free[pos]   = 1'b1;
               link_prev[pos] = '0;
               link_next[pos] = free_top;
               free_top       = pos;
               if (in_use > 0) in_use--;
            end
         end
      end else begin
         case (op)
            OP_PUSH_FRONT: anchor = 8'd0;
            OP_PUSH_BACK:  anchor = link_prev[0];
            default:       anchor = pos;
         endcase
         if (is_free[anchor]) begin
            r.status = ST_INACTIVE;
         end else if (in_use >= NODES || free_top == 8'd0) begin
            r.status = ST_FULL;
         end else begin
            if (link_prev[0] != anchor) ordered = 1'b0;
            fresh    = free_top;
            after    = link_next[anchor];
            free_top = link_next[fresh];
            link_prev[fresh]  = anchor;
            link_next[fresh]  = after;
            payload[fresh]    = v;
            is_free[fresh]    = 1'b0;
            link_next[anchor] = fresh;
            link_prev[after]  = fresh;
            in_use++;
            r.new_index = fresh;
         end
      end
      r.in_order = ordered;
      return r;
   endfunction

   // start stays high from one word to the next unless the sender chooses to idle
   task automatic send_word(input opcode_type op, input logic [7:0] pos,
                            input logic signed [31:0] v);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_outcomes.push_back(apply_list_op(op, pos, v));
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3:       return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // mostly a random live node, sometimes the tail; sentinel when empty
   function automatic logic [7:0] pick_live_node();
      logic [7:0] idx;
      if (in_use == 0) return 8'd0;
      if ($urandom_range(4) == 0) return link_prev[0];
      idx = 8'($urandom_range(NODES, 1));
      while (is_free[idx]) idx = (idx == 8'(NODES)) ? 8'd1 : idx + 8'd1;
      return idx;
   endfunction

   task automatic test_directed();
      send_word(OP_DELETE, 8'd0, 32'sd5);
      send_word(OP_PUSH_BACK, 8'd17, 32'sh7fff_ffff);
      send_word(OP_PUSH_BACK, 8'd0, 32'sh8000_0000);
      send_word(OP_INSERT_AFTER, link_prev[0], -32'sd1);
      send_word(OP_INSERT_AFTER, 8'd200, 32'sd9);
      send_word(OP_DELETE, link_prev[0], 32'sd0);
      send_word(OP_PUSH_BACK, 8'd0, 32'sd0);
      send_word(OP_INSERT_AFTER, 8'd255, 32'sd1);
      // first insert away from the tail, order flag goes for good
      send_word(OP_PUSH_FRONT, 8'd255, 32'sd12345);
      send_word(OP_INSERT_AFTER, 8'd0, -32'sd77);
      send_word(OP_INSERT_AFTER, 8'd1, 32'sh5555_aaaa);
      send_word(OP_DELETE, 8'd255, 32'sd0);
      send_word(OP_DELETE, 8'd1, 32'sd0);
      send_word(OP_DELETE, 8'd2, 32'sd0);
      send_word(OP_DELETE, 8'd2, 32'sd0);
      while (in_use > 0) send_word(OP_DELETE, link_prev[0], 32'sd0);
      // push back on an empty list lands after the sentinel
      send_word(OP_PUSH_BACK, 8'd0, 32'sh0f0f_0f0f);
      send_word(OP_DELETE, link_next[0], 32'sd0);
   endtask

   task automatic test_store_full();
      while (in_use < NODES) send_word(OP_PUSH_BACK, 8'($urandom), random_value());
      send_word(OP_INSERT_AFTER, link_prev[0], 32'sd1);
      send_word(OP_INSERT_AFTER, 8'd0, 32'sd2);
      send_word(OP_PUSH_FRONT, 8'd0, 32'sd3);
      send_word(OP_PUSH_BACK, 8'd0, 32'sd4);
      send_word(OP_DELETE, link_next[0], 32'sd0);
      send_word(OP_DELETE, link_prev[0], 32'sd0);
      send_word(OP_DELETE, pick_live_node(), 32'sd0);
      send_word(OP_PUSH_BACK, 8'd0, random_value());
      send_word(OP_INSERT_AFTER, pick_live_node(), random_value());
   endtask

   task automatic test_random_traffic(input int count, input int sender_idle);
      int roll;
      int insert_pct;
      idle_pct = sender_idle;
      for (int n = 0; n < count; n++) begin
         // alternate filling and draining so both the full and empty ends get visited
         insert_pct = ((n / 100) % 2 == 0) ? 65 : 27;
         roll = $urandom_range(99);
         if (roll < 8) begin
            send_word(opcode_type'($urandom_range(3)), 8'($urandom), $urandom);
         end else if (roll < 8 + insert_pct) begin
            case ($urandom_range(2))
               0:       send_word(OP_INSERT_AFTER, pick_live_node(), random_value());
               1:       send_word(OP_PUSH_FRONT, 8'($urandom), random_value());
               default: send_word(OP_PUSH_BACK, 8'($urandom), random_value());
            endcase
         end else begin
            send_word(OP_DELETE, pick_live_node(), $urandom);
         end
      end
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_outcomes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result word: idx %0d val %0d st %0d ord %0b",
                        rsp_new_index, rsp_removed_value, rsp_status, rsp_in_order);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_new_index !== want.new_index ||
                rsp_removed_value !== want.removed_value ||
                rsp_status !== want.status || rsp_in_order !== want.in_order) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
                           want.new_index, want.removed_value, want.status, want.in_order,
                           rsp_new_index, rsp_removed_value, rsp_status, rsp_in_order);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      clear_list_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 35;
      test_directed();
      test_store_full();
      test_random_traffic(600, 35);
      test_random_traffic(600, 77);
      test_random_traffic(600, 0);
      start <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/allm_pkg.sv
design/allm_ram.sv
design/array_linked_list_manager.sv
design/allm_checker.sv
tb/tb_top.sv
